// File: rtl/core/crf_pkg.sv
// Shared types and constants for the comb resonator filter unit.
package crf_pkg;

	localparam int unsigned CRF_MAX_DELAY = 128;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned SCALED_W = 18;
	localparam int unsigned COMB_W   = SCALED_W + 1;
	localparam int unsigned OUT_W    = 32;
	localparam int unsigned PADDR_W  = 4;

	localparam logic [15:0] GAIN_RST  = 16'h4000;
	localparam logic [7:0]  DELAY_RST = 8'd64;
	localparam logic [15:0] COEF_RST  = 16'h0000;
	localparam logic [15:0] R2_RST    = 16'h0000;

	typedef enum logic [1:0] {
		REG_INPUT_GAIN,
		REG_COMB_DELAY,
		REG_RES_COEF,
		REG_POLE_R2
	} crf_reg_t;

	typedef struct packed {
		logic signed [15:0] input_gain;
		logic [7:0]         comb_delay;
		logic signed [15:0] resonator_coef;
		logic [15:0]        pole_radius_sq;
	} crf_cfg_t;

	// take: a beat enters stage 1; advance: the stage 1 beat moves to the result register
	typedef struct packed {
		logic take;
		logic advance;
	} crf_step_t;

endpackage

// File: rtl/core/comb_resonator_filter_unit.sv
// Top level of the comb resonator filter: config registers, pipeline control, result register.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  in       | sink      | in_valid / in_stall  | sample, last_in_frame
//  out      | source    | out_valid / out_stall| filtered_out, last_out
//  apb      | slave     | psel/penable/pready  | paddr, pwdata, prdata
//
// One beat per cycle sustained while out_stall stays low; an accepted beat waits in stage 1
// and then moves to the result register. Stage 1 holds the scaled sample and the registered
// delay-store read; the resonator recurrence closes in that same cycle, so the rate is set
// by its feedback loop through y1_q. Reset clears history, pointer and fill count at once
// (no clearing pass). in_stall rises only when stage 1 is full and the result register is
// held by out_stall.
module comb_resonator_filter_unit #(
	parameter int unsigned MAX_COMB_DELAY = crf_pkg::CRF_MAX_DELAY
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [crf_pkg::SAMPLE_W-1:0] sample,
	input  logic                                last_in_frame,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [crf_pkg::OUT_W-1:0]    filtered_out,
	output logic                                last_out,

	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [crf_pkg::PADDR_W-1:0]         paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import crf_pkg::*;

	crf_cfg_t  cfg_q;
	crf_step_t step;
	crf_reg_t  reg_sel;

	logic valid_s1;
	logic last_s1;
	logic valid_s2;
	logic last_s2;
	logic signed [OUT_W-1:0] filt_s2;

	logic signed [31:0] gain_prod;
	logic signed [SCALED_W-1:0] scaled_in;
	logic signed [COMB_W-1:0] comb_s1;
	logic signed [OUT_W-1:0] y_s1;
	logic wr_en;

	// configuration port
	assign pready  = 1'b1;
	assign reg_sel = crf_reg_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_gain     <= GAIN_RST;
			cfg_q.comb_delay     <= DELAY_RST;
			cfg_q.resonator_coef <= COEF_RST;
			cfg_q.pole_radius_sq <= R2_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_INPUT_GAIN: cfg_q.input_gain     <= pwdata[15:0];
				REG_COMB_DELAY: cfg_q.comb_delay     <= pwdata[7:0];
				REG_RES_COEF:   cfg_q.resonator_coef <= pwdata[15:0];
				REG_POLE_R2:    cfg_q.pole_radius_sq <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_INPUT_GAIN: prdata = {16'h0000, cfg_q.input_gain};
			REG_COMB_DELAY: prdata = {24'h000000, cfg_q.comb_delay};
			REG_RES_COEF:   prdata = {16'h0000, cfg_q.resonator_coef};
			REG_POLE_R2:    prdata = {16'h0000, cfg_q.pole_radius_sq};
			default:        prdata = '0;
		endcase
	end

	// pipeline control
	assign step.advance = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall     = valid_s1 && !step.advance;
	assign step.take    = in_valid && !in_stall;

	// Q2.14 gain, floor shift; the result always fits 18 bits
	assign gain_prod = sample * cfg_q.input_gain;
	assign scaled_in = gain_prod[31:14];

	crf_comb #(
		.MAX_COMB_DELAY(MAX_COMB_DELAY)
	) u_comb (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.comb_delay(cfg_q.comb_delay),
		.scaled_in (scaled_in),
		.comb_out  (comb_s1)
	);

	crf_resonator u_res (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cfg    (cfg_q),
		.comb_in(comb_s1),
		.y_out  (y_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (step.take) begin
				valid_s1 <= 1'b1;
			end else if (step.advance) begin
				valid_s1 <= 1'b0;
			end
			if (step.advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step.take) begin
			last_s1 <= last_in_frame;
		end
		if (step.advance) begin
			filt_s2 <= y_s1;
			last_s2 <= last_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign filtered_out = filt_s2;
	assign last_out     = last_s2;

endmodule

// File: rtl/core/crf_comb.sv
// Comb section: delay store, write pointer, fill count and read bypass.
module crf_comb #(
	parameter int unsigned MAX_COMB_DELAY = crf_pkg::CRF_MAX_DELAY
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  crf_pkg::crf_step_t                   step,
	input  logic [7:0]                           comb_delay,
	input  logic signed [crf_pkg::SCALED_W-1:0]  scaled_in,
	output logic signed [crf_pkg::COMB_W-1:0]    comb_out
);
	import crf_pkg::*;

	localparam int unsigned D  = MAX_COMB_DELAY;
	localparam int unsigned PW = (D > 1) ? $clog2(D) : 1;
	localparam int unsigned FW = $clog2(D + 1);
	localparam int unsigned NW = (FW > 8) ? FW : 8;
	localparam int unsigned AW = NW + 1;

	logic signed [SCALED_W-1:0] mem [0:D-1];

	logic [PW-1:0] wp_q;
	logic [FW-1:0] fill_q;
	logic [PW-1:0] wp_s1;
	logic signed [SCALED_W-1:0] scaled_s1;
	logic signed [SCALED_W-1:0] rdata_s1;
	logic signed [SCALED_W-1:0] byp_s1;
	logic hit_s1;
	logic rdok_s1;

	logic [NW-1:0] n_ext;
	logic [NW-1:0] n_cl;
	logic [AW-1:0] rd_sum;
	logic [AW-1:0] rd_full;
	logic [PW-1:0] rd_addr;
	logic rd_ok;
	logic hit;
	logic signed [SCALED_W-1:0] delayed;

	// zero acts as one, anything past the store depth is clamped
	always_comb begin
		n_ext = NW'(comb_delay);
		if (n_ext == '0) begin
			n_cl = NW'(1);
		end else if (n_ext > NW'(D)) begin
			n_cl = NW'(D);
		end else begin
			n_cl = n_ext;
		end
	end

	assign rd_sum  = AW'(wp_q) + AW'(D) - AW'(n_cl);
	assign rd_full = (rd_sum >= AW'(D)) ? (rd_sum - AW'(D)) : rd_sum;
	assign rd_addr = rd_full[PW-1:0];
	// entries are filled in address order, so the count tells which were written
	assign rd_ok   = AW'(rd_addr) < AW'(fill_q);
	// the stage 1 beat writes this slot on the same edge the read happens
	assign hit     = step.advance && (wp_s1 == rd_addr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (step.take) begin
			if (wp_q == PW'(D - 1)) begin
				wp_q <= '0;
			end else begin
				wp_q <= wp_q + PW'(1);
			end
			if (fill_q != FW'(D)) begin
				fill_q <= fill_q + FW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step.advance) begin
			mem[wp_s1] <= scaled_s1;
		end
		if (step.take) begin
			rdata_s1  <= mem[rd_addr];
			wp_s1     <= wp_q;
			scaled_s1 <= scaled_in;
			hit_s1    <= hit;
			rdok_s1   <= rd_ok;
			byp_s1    <= scaled_s1;
		end
	end

	assign delayed  = hit_s1 ? byp_s1 : (rdok_s1 ? rdata_s1 : '0);
	assign comb_out = COMB_W'(scaled_s1) - COMB_W'(delayed);

endmodule

// File: rtl/core/crf_resonator.sv
// Two-pole resonator: history registers, coefficient products and saturation.
module crf_resonator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  crf_pkg::crf_step_t                 step,
	input  crf_pkg::crf_cfg_t                  cfg,
	input  logic signed [crf_pkg::COMB_W-1:0]  comb_in,
	output logic signed [crf_pkg::OUT_W-1:0]   y_out
);
	import crf_pkg::*;

	localparam logic signed [35:0] SAT_HI = 36'sh07FFFFFFF;
	localparam logic signed [35:0] SAT_LO = 36'shF80000000;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI) begin
			r = 32'sh7FFFFFFF;
		end else if (v < SAT_LO) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	logic signed [31:0] y1_q;
	logic signed [31:0] y2_q;

	logic signed [15:0] coef;
	logic signed [16:0] r2s;
	logic signed [47:0] p1_full;
	logic signed [48:0] p2_full;
	logic signed [33:0] p1;
	logic signed [33:0] p2;
	logic signed [35:0] fb_full;
	logic signed [31:0] fb;
	logic signed [35:0] y_full;

	assign coef    = cfg.resonator_coef;
	assign r2s     = {1'b0, cfg.pole_radius_sq};
	assign p1_full = coef * y1_q;
	assign p2_full = r2s * y2_q;
	// floor shifts: Q2.14 and Q1.15
	assign p1      = p1_full[47:14];
	assign p2      = p2_full[48:15];
	assign fb_full = 36'(comb_in) + 36'(p1) - 36'(p2);
	assign fb      = sat32(fb_full);
	assign y_full  = 36'(fb) - 36'(p1);
	assign y_out   = sat32(y_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y1_q <= '0;
			y2_q <= '0;
		end else if (step.advance) begin
			y2_q <= y1_q;
			y1_q <= fb;
		end
	end

endmodule

// File: sim/comb_resonator_filter_unit_tb.sv
// Self-checking testbench for the comb resonator filter unit: directed corners, then random stream.
module comb_resonator_filter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import crf_pkg::*;

	localparam int TOTAL_SAMPLES = 1750;
	localparam int CYCLE_LIMIT   = 400000;

	typedef struct packed {
		logic signed [OUT_W-1:0] value;
		logic                    last;
	} filt_out_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_in_frame;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [OUT_W-1:0]    filtered_out;
	logic                       last_out;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [PADDR_W-1:0]         paddr;
	logic [31:0]                pwdata;
	logic [31:0]                prdata;
	logic                       pready;

	// filter state as the block should hold it
	logic signed [SCALED_W-1:0] scaled_hist [0:CRF_MAX_DELAY-1];
	logic [6:0]                 hist_wr;
	logic signed [31:0]         y1_m;
	logic signed [31:0]         y2_m;
	logic signed [15:0]         gain_m;
	logic [7:0]                 delay_m;
	logic signed [15:0]         coef_m;
	logic [15:0]                r2_m;

	filt_out_t pending_outputs [$];
	filt_out_t want;
	int        mismatches;
	int        outputs_checked;
	int        samples_sent;
	int        reg_writes;
	int        settings_used;
	int        cycles;
	bit        calm;

	comb_resonator_filter_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.last_in_frame(last_in_frame),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.filtered_out (filtered_out),
		.last_out     (last_out),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_mismatch(string what);
		if (mismatches < 30)
			$display("MISMATCH @%0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// one sample through gain, comb and resonator; advances the state
	function automatic filt_out_t resonate_sample(logic signed [15:0] s, logic lf);
		longint      scaled, comb, p1, p2, fb;
		int unsigned n;
		logic [6:0]  rd;
		filt_out_t   r;
		n = delay_m;
		if (n < 1)
			n = 1;
		if (n > CRF_MAX_DELAY)
			n = CRF_MAX_DELAY;
		scaled = (longint'(s) * longint'(gain_m)) >>> 14;
		rd = hist_wr - 7'(n);
		comb = scaled - longint'(scaled_hist[rd]);
		scaled_hist[hist_wr] = SCALED_W'(scaled);
		hist_wr++;
		p1 = (longint'(coef_m) * longint'(y1_m)) >>> 14;
		p2 = (longint'(r2_m) * longint'(y2_m)) >>> 15;
		fb = sat32(comb + p1 - p2);
		r.value = 32'(sat32(fb - p1));
		r.last = lf;
		y2_m = y1_m;
		y1_m = 32'(fb);
		return r;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d outputs outstanding", cycles,
				pending_outputs.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outputs.size() == 0) begin
				flag_mismatch($sformatf("unexpected output %0d", filtered_out));
			end else begin
				want = pending_outputs.pop_front();
				outputs_checked++;
				if (filtered_out !== want.value)
					flag_mismatch($sformatf("filtered_out %0d, expected %0d",
						filtered_out, want.value));
				if (last_out !== want.last)
					flag_mismatch($sformatf("last_out %b, expected %b", last_out, want.last));
			end
		end
	end

	// downstream backpressure in random bursts
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	task automatic push_sample(logic signed [15:0] s, logic lf);
		@(negedge clk);
		in_valid = 1'b1;
		sample = s;
		last_in_frame = lf;
		do @(posedge clk); while (in_stall);
		pending_outputs.push_back(resonate_sample(s, lf));
		samples_sent++;
	endtask

	task automatic hold_input(int n);
		@(negedge clk);
		in_valid = 1'b0;
		sample = 16'($urandom);
		last_in_frame = 1'($urandom);
		repeat (n - 1) @(negedge clk);
	endtask

	// wait for the pipe to empty so registers may be touched
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_reg(crf_reg_t idx);
		logic [31:0] got;
		logic [15:0] got_v, want_v;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		case (idx)
			REG_INPUT_GAIN: want_v = gain_m;
			REG_COMB_DELAY: want_v = {8'h00, delay_m};
			REG_RES_COEF:   want_v = coef_m;
			default:        want_v = r2_m;
		endcase
		got_v = (idx == REG_COMB_DELAY) ? {8'h00, got[7:0]} : got[15:0];
		if (got_v !== want_v)
			flag_mismatch($sformatf("%s reads %h, expected %h", idx.name(), got_v, want_v));
	endtask

	task automatic write_reg(crf_reg_t idx, logic [31:0] v);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_INPUT_GAIN: gain_m = v[15:0];
			REG_COMB_DELAY: delay_m = v[7:0];
			REG_RES_COEF:   coef_m = v[15:0];
			default:        r2_m = v[15:0];
		endcase
		reg_writes++;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		check_reg(idx);
	endtask

	// defaults after reset; early taps of the delay store read as zero
	task automatic test_reset_values();
		check_reg(REG_INPUT_GAIN);
		check_reg(REG_COMB_DELAY);
		check_reg(REG_RES_COEF);
		check_reg(REG_POLE_R2);
		push_sample(16'sh7fff, 1'b0);
		push_sample(16'sh8000, 1'b1);
		push_sample(16'sh0001, 1'b0);
		push_sample(-16'sh0001, 1'b1);
	endtask

	task automatic test_gain_extremes();
		settle();
		write_reg(REG_INPUT_GAIN, 32'hffff_8000);
		write_reg(REG_COMB_DELAY, 32'd1);
		push_sample(16'sh7fff, 1'b0);
		push_sample(16'sh8000, 1'b0);
		settle();
		write_reg(REG_INPUT_GAIN, 32'h0000_7fff);
		push_sample(16'sh8000, 1'b1);
		push_sample(16'sh7fff, 1'b0);
		push_sample(16'sh0000, 1'b1);
	endtask

	// zero delay acts as one, anything past the store depth as the full depth
	task automatic test_delay_limits();
		settle();
		write_reg(REG_COMB_DELAY, 32'd0);
		push_sample(16'sh1234, 1'b0);
		push_sample(16'shedcb, 1'b0);
		settle();
		write_reg(REG_COMB_DELAY, 32'd128);
		push_sample(16'sh4000, 1'b0);
		push_sample(16'shc000, 1'b1);
		settle();
		write_reg(REG_COMB_DELAY, 32'd255);
		push_sample(16'sh7fff, 1'b0);
		push_sample(16'sh8000, 1'b0);
		settle();
		write_reg(REG_COMB_DELAY, 32'd129);
		push_sample(16'sh5555, 1'b1);
	endtask

	task automatic test_resonator_extremes();
		settle();
		write_reg(REG_INPUT_GAIN, 32'h0000_7fff);
		write_reg(REG_RES_COEF, 32'h0000_7fff);
		write_reg(REG_POLE_R2, 32'h0000_ffff);
		repeat (4) push_sample(16'sh7fff, 1'b0);
		settle();
		write_reg(REG_RES_COEF, 32'hffff_8000);
		write_reg(REG_POLE_R2, 32'h0000_8000);
		repeat (4) push_sample(16'sh8000, 1'b1);
	endtask

	task automatic test_random_stream();
		int                 count, bound, cv;
		int unsigned        r2v;
		logic signed [15:0] s;
		while (samples_sent < TOTAL_SAMPLES) begin
			settle();
			settings_used++;
			if ($urandom_range(0, 1))
				case ($urandom_range(0, 4))
					0:       write_reg(REG_INPUT_GAIN, 32'hffff_8000);
					1:       write_reg(REG_INPUT_GAIN, 32'h0000_7fff);
					2:       write_reg(REG_INPUT_GAIN, 32'h0000_4000);
					default: write_reg(REG_INPUT_GAIN, $urandom);
				endcase
			if ($urandom_range(0, 1))
				case ($urandom_range(0, 7))
					0:       write_reg(REG_COMB_DELAY, 32'd0);
					1:       write_reg(REG_COMB_DELAY, 32'd1);
					2:       write_reg(REG_COMB_DELAY, 32'd128);
					3:       write_reg(REG_COMB_DELAY, 32'd255);
					4:       write_reg(REG_COMB_DELAY, $urandom_range(129, 254));
					default: write_reg(REG_COMB_DELAY, $urandom_range(1, 128));
				endcase
			if ($urandom_range(0, 1))
				case ($urandom_range(0, 3))
					0: begin
						write_reg(REG_RES_COEF, $urandom_range(0, 1) ? 32'h7fff : 32'hffff_8000);
						case ($urandom_range(0, 2))
							0:       write_reg(REG_POLE_R2, 32'd0);
							1:       write_reg(REG_POLE_R2, 32'd32768);
							default: write_reg(REG_POLE_R2, 32'd65535);
						endcase
					end
					1: begin
						write_reg(REG_RES_COEF, 32'd0);
						write_reg(REG_POLE_R2, 32'd0);
					end
					default: begin
						// poles inside the unit circle keep the output in range
						r2v = $urandom_range(20000, 32700);
						bound = int'(1.9 * $sqrt(real'(r2v) / 32768.0) * 16384.0);
						cv = int'($urandom_range(0, 2 * bound)) - bound;
						write_reg(REG_RES_COEF, 32'(cv));
						write_reg(REG_POLE_R2, 32'(r2v));
					end
				endcase
			count = $urandom_range(60, 180);
			if (TOTAL_SAMPLES - samples_sent <= 200) begin
				count = TOTAL_SAMPLES - samples_sent;
				calm = 1'b1;
			end else begin
				calm = ($urandom_range(0, 3) == 0);
			end
			repeat (count) begin
				case ($urandom_range(0, 7))
					0:       s = 16'sh7fff;
					1:       s = 16'sh8000;
					2:       s = 16'(int'($urandom_range(0, 64)) - 32);
					default: s = 16'($urandom);
				endcase
				if (!calm && $urandom_range(0, 6) == 0)
					hold_input($urandom_range(1, 14));
				push_sample(s, $urandom_range(0, 9) == 0);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		last_in_frame = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		calm = 1'b0;
		cycles = 0;
		mismatches = 0;
		outputs_checked = 0;
		samples_sent = 0;
		reg_writes = 0;
		settings_used = 0;
		foreach (scaled_hist[i])
			scaled_hist[i] = '0;
		hist_wr = '0;
		y1_m = '0;
		y2_m = '0;
		gain_m = GAIN_RST;
		delay_m = DELAY_RST;
		coef_m = COEF_RST;
		r2_m = R2_RST;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_gain_extremes();
		test_delay_limits();
		test_resonator_extremes();
		test_random_stream();

		settle();
		repeat (10) @(posedge clk);
		$display("Ran %0d samples through %0d random settings plus corners, %0d register writes.",
			samples_sent, settings_used, reg_writes);
		$display("Compared %0d outputs, %0d mismatches.", outputs_checked, mismatches);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/crf_pkg.sv
rtl/core/crf_comb.sv
rtl/core/crf_resonator.sv
rtl/core/comb_resonator_filter_unit.sv
sim/comb_resonator_filter_unit_tb.sv
